// ----- sv/jsue_pkg.sv -----
// Shared types and constants for the JSON string escaper.
`default_nettype none
package jsue_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [7:0] CH_UP_D = 8'h44;

  // Body of one request's output between the optional quotes.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LIT,
    KIND_ESC,
    KIND_UNI,
    KIND_FAIL
  } kind_t;

  typedef struct packed {
    logic        open_q;
    kind_t       kind;
    logic [7:0]  body_char;
    logic [15:0] code;
    logic        close_q;
  } cmd_t;

endpackage
`default_nettype wire

// ----- sv/jsue_front.sv -----
// Front end: UTF-8 decoding state and classification of each request.
`default_nettype none
module jsue_front
  import jsue_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_of_string,
  input  wire logic       last_of_string,
  input  wire logic       empty_string,
  output cmd_t            cmd,
  output logic            cmd_push
);

  logic [15:0] code_accum_r, code_accum_nxt;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic        dropping_r, dropping_nxt;

  always_comb begin
    logic [15:0] acc;
    logic [15:0] acc_sh;
    logic [1:0]  bl;
    logic        drop;
    logic        fail;
    acc = code_accum_r;
    bl = bytes_left_r;
    drop = dropping_r;
    fail = 1'b0;
    acc_sh = 16'h0;
    cmd = '0;
    cmd.kind = KIND_NONE;
    cmd.body_char = data_byte;
    if (empty_string) begin
      acc = 16'h0;
      bl = 2'd0;
      drop = 1'b0;
      cmd.open_q = 1'b1;
      cmd.close_q = 1'b1;
    end else begin
      if (first_of_string) begin
        acc = 16'h0;
        bl = 2'd0;
        drop = 1'b0;
        cmd.open_q = 1'b1;
      end
      if (drop) begin
        if (last_of_string) begin
          drop = 1'b0;
        end
      end else if (bl != 2'd0) begin
        if (data_byte[7:6] != 2'b10) begin
          fail = 1'b1;
        end else begin
          acc_sh = {acc[9:0], data_byte[5:0]};
          bl = bl - 2'd1;
          if (bl == 2'd0) begin
            cmd.kind = KIND_UNI;
            cmd.code = acc_sh;
            acc = 16'h0;
            cmd.close_q = last_of_string;
          end else if (last_of_string) begin
            fail = 1'b1;
          end else begin
            acc = acc_sh;
          end
        end
      end else if (data_byte == 8'h08 || data_byte == 8'h0C || data_byte == 8'h0D) begin
        cmd.close_q = last_of_string;
      end else if (data_byte == 8'h0A) begin
        cmd.kind = KIND_ESC;
        cmd.body_char = CH_LOW_N;
        cmd.close_q = last_of_string;
      end else if (data_byte == 8'h09) begin
        cmd.kind = KIND_ESC;
        cmd.body_char = CH_LOW_T;
        cmd.close_q = last_of_string;
      end else if (data_byte[7] || data_byte < 8'd32) begin
        if (data_byte[7:5] == 3'b110) begin
          acc = {11'h0, data_byte[4:0]};
          bl = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          acc = {12'h0, data_byte[3:0]};
          bl = 2'd2;
        end else begin
          fail = 1'b1;
        end
        if (last_of_string) begin
          fail = 1'b1;
        end
      end else begin
        cmd.kind = (data_byte == CH_QUOTE || data_byte == CH_BSLASH) ? KIND_ESC : KIND_LIT;
        cmd.close_q = last_of_string;
      end
      if (fail) begin
        cmd.kind = KIND_FAIL;
        cmd.close_q = 1'b1;
        acc = 16'h0;
        bl = 2'd0;
        drop = !last_of_string;
      end
    end
    code_accum_nxt = acc;
    bytes_left_nxt = bl;
    dropping_nxt = drop;
    cmd_push = accept && (cmd.open_q || cmd.close_q || cmd.kind != KIND_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_accum_r <= 16'h0;
      bytes_left_r <= 2'd0;
      dropping_r <= 1'b0;
    end else if (accept) begin
      code_accum_r <= code_accum_nxt;
      bytes_left_r <= bytes_left_nxt;
      dropping_r <= dropping_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/jsue_cmdq.sv -----
// Short command queue between the front end and the character emitter.
`default_nettype none
module jsue_cmdq
  import jsue_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- sv/jsue_back.sv -----
// Character emitter: expands each queued command into output characters.
`default_nettype none
module jsue_back
  import jsue_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       head_cmd,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_closes_string
);

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

  function automatic logic [3:0] body_len(input kind_t k);
    unique case (k)
      KIND_NONE: body_len = 4'd0;
      KIND_LIT:  body_len = 4'd1;
      KIND_ESC:  body_len = 4'd2;
      KIND_UNI:  body_len = 4'd6;
      KIND_FAIL: body_len = 4'd6;
      default:   body_len = 4'd0;
    endcase
  endfunction

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_run_last_r;
  logic       out_closes_r;

  logic       load;
  logic [3:0] total;
  logic [3:0] pos;
  logic [3:0] blen;
  logic       is_last;
  logic [7:0] ch;
  logic       ch_close;

  assign blen = body_len(head_cmd.kind);
  assign total = {3'b0, head_cmd.open_q} + blen + {3'b0, head_cmd.close_q};
  assign is_last = ({1'b0, step_r} == total - 4'd1);
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop = load && is_last;

  always_comb begin
    pos = {1'b0, step_r} - {3'b0, head_cmd.open_q};
    ch = CH_QUOTE;
    ch_close = 1'b0;
    if (head_cmd.open_q && step_r == 3'd0) begin
      ch = CH_QUOTE;
    end else if (pos < blen) begin
      unique case (head_cmd.kind)
        KIND_LIT: ch = head_cmd.body_char;
        KIND_ESC: ch = (pos == 4'd0) ? CH_BSLASH : head_cmd.body_char;
        KIND_UNI: begin
          unique case (pos)
            4'd0:    ch = CH_BSLASH;
            4'd1:    ch = CH_LOW_U;
            4'd2:    ch = hex_char(head_cmd.code[15:12]);
            4'd3:    ch = hex_char(head_cmd.code[11:8]);
            4'd4:    ch = hex_char(head_cmd.code[7:4]);
            default: ch = hex_char(head_cmd.code[3:0]);
          endcase
        end
        KIND_FAIL: begin
          unique case (pos)
            4'd0:    ch = CH_BSLASH;
            4'd1:    ch = CH_LOW_U;
            4'd5:    ch = CH_UP_D;
            default: ch = CH_UP_F;
          endcase
        end
        default: ch = CH_QUOTE;
      endcase
    end else begin
      ch = CH_QUOTE;
      ch_close = 1'b1;
    end
    step_nxt = step_r;
    if (load) begin
      step_nxt = is_last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= ch;
      out_run_last_r <= is_last;
      out_closes_r <= ch_close;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char = out_char_r;
  assign out_run_last = out_run_last_r;
  assign out_closes_string = out_closes_r;

  a_close_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_closes_r |-> out_char_r == CH_QUOTE && out_run_last_r)
    else $error("closing character is not a final quote");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> {1'b0, step_r} < total)
    else $error("emitter step runs past the command length");

  a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == 3'd0)
    else $error("emitter step not cleared after finishing a command");

endmodule
`default_nettype wire

// ----- sv/json_string_utf8_escaper.sv -----
// Top level of the JSON string escaper for UTF-8 byte streams.
//
// Input requests carry one string byte (in_data_byte) with first/last flags,
// or an empty-string marker. Output requests carry one ASCII character of the
// quoted JSON literal, with out_run_last on the final character caused by an
// input request and out_closes_string on the closing quote.
// Both channels use valid/ready; a request moves when both are high.
// The front end decodes UTF-8 and classifies each byte in the accept cycle,
// then pushes a compact command into a four-entry queue. The emitter expands
// each command into one to eight characters, one per cycle while the receiver
// is ready, into a registered output stage. Plain ASCII therefore flows at one
// byte per cycle; out_valid rises once the command has passed through the
// queue and the output register. An escape of N characters holds the emitter
// until all N are out, and the queue absorbs short bursts of those.
// in_ready drops only while the queue is full, so a stalled receiver stops
// the input after the queue fills, and no character is lost or repeated.
// Synchronous active-low reset clears the decoder state, empties the queue
// and drops any pending output character.
`default_nettype none
module json_string_utf8_escaper
  import jsue_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_of_string,
  input  wire logic       in_last_of_string,
  input  wire logic       in_empty_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_closes_string
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic head_valid;
  logic pop;
  logic accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // Decoder state advances on every accepted request; requests that cause
  // no character (dropped bytes, partial sequences) push nothing.
  jsue_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_data_byte),
    .first_of_string (in_first_of_string),
    .last_of_string  (in_last_of_string),
    .empty_string    (in_empty_string),
    .cmd             (front_cmd),
    .cmd_push        (push)
  );

  jsue_cmdq #(
    .DEPTH (QDEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid)
  );

  // The emitter walks each command one character per cycle while the receiver is ready.
  jsue_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .head_valid        (head_valid),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_closes_string (out_closes_string)
  );

endmodule
`default_nettype wire

// ----- verif/json_escape_tb_pkg.sv -----
// Byte codes and the character record shared by the escaper testbench files.
`timescale 1ns / 100ps
package json_escape_tb_pkg;

  // Control bytes that the escaper treats specially.
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  // First byte that is not a control character.
  localparam logic [7:0] BYTE_PRINT_LOW = 8'h20;
  // From here up a byte belongs to a multi-byte sequence or is invalid.
  localparam logic [7:0] BYTE_HIGH_HALF = 8'h80;

  // UTF-8 lead and continuation patterns.
  localparam logic [7:0] MASK_CONT    = 8'hC0;
  localparam logic [7:0] TAG_CONT     = 8'h80;
  localparam logic [7:0] MASK_LEAD2   = 8'hE0;
  localparam logic [7:0] TAG_LEAD2    = 8'hC0;
  localparam logic [7:0] MASK_LEAD3   = 8'hF0;
  localparam logic [7:0] TAG_LEAD3    = 8'hE0;

  // One character of the escaped literal as it appears on the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       closes;
  } json_char_t;

endpackage

// ----- verif/json_escape_checker.sv -----
// Checker that predicts the escaped JSON characters and compares the output channel.
`timescale 1ns / 100ps
module json_escape_checker
  import jsue_pkg::*;
  import json_escape_tb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_string,
  input  logic       in_last_of_string,
  input  logic       in_empty_string,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_run_last,
  input  logic       out_closes_string,
  output int         mismatch_count,
  output int         chars_pending,
  output int         chars_checked
);

  json_char_t expected_chars[$];
  json_char_t item_chars[$];
  json_char_t want;

  // Decoder state kept by the prediction.
  logic [15:0] cp_accum;
  logic [1:0]  cont_left;
  logic        skip_rest;

  int errs;
  int checked;

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return "0" + {4'd0, nib};
    end
    return "a" + {4'd0, nib} - 8'd10;
  endfunction

  task automatic put_char(input logic [7:0] c, input logic cl);
    item_chars.insert(item_chars.size(), {c, 1'b0, cl});
  endtask

  task automatic put_code(input logic [15:0] v);
    int i;
    put_char(CH_BSLASH, 1'b0);
    put_char(CH_LOW_U, 1'b0);
    for (i = 3; i >= 0; i--) begin
      put_char(hex_lower(v[4*i +: 4]), 1'b0);
    end
  endtask

  // Replacement escape, closing quote, then the rest of the string is dropped.
  task automatic fail_string(input logic last);
    put_char(CH_BSLASH, 1'b0);
    put_char(CH_LOW_U, 1'b0);
    put_char(CH_UP_F, 1'b0);
    put_char(CH_UP_F, 1'b0);
    put_char(CH_UP_F, 1'b0);
    put_char(CH_UP_D, 1'b0);
    put_char(CH_QUOTE, 1'b1);
    cp_accum  = '0;
    cont_left = '0;
    skip_rest = !last;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    if (cont_left != 2'd0) begin
      if ((b & MASK_CONT) != TAG_CONT) begin
        fail_string(last);
        return;
      end
      cp_accum  = {cp_accum[9:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        put_code(cp_accum);
        cp_accum = '0;
      end else if (last) begin
        fail_string(last);
        return;
      end
    end else if (b == BYTE_BS || b == BYTE_FF || b == BYTE_CR) begin
      // Silently dropped.
    end else if (b == BYTE_LF) begin
      put_char(CH_BSLASH, 1'b0);
      put_char(CH_LOW_N, 1'b0);
    end else if (b == BYTE_TAB) begin
      put_char(CH_BSLASH, 1'b0);
      put_char(CH_LOW_T, 1'b0);
    end else if (b >= BYTE_HIGH_HALF || b < BYTE_PRINT_LOW) begin
      if ((b & MASK_LEAD2) == TAG_LEAD2) begin
        cp_accum  = {11'd0, b[4:0]};
        cont_left = 2'd1;
      end else if ((b & MASK_LEAD3) == TAG_LEAD3) begin
        cp_accum  = {12'd0, b[3:0]};
        cont_left = 2'd2;
      end else begin
        fail_string(last);
        return;
      end
      if (last) begin
        fail_string(last);
        return;
      end
    end else begin
      if (b == CH_QUOTE || b == CH_BSLASH) begin
        put_char(CH_BSLASH, 1'b0);
      end
      put_char(b, 1'b0);
    end
    if (last) begin
      put_char(CH_QUOTE, 1'b1);
    end
  endtask

  task automatic predict_escape(input logic [7:0] b, input logic first,
                                input logic last, input logic empty);
    int k;
    item_chars.delete();
    if (empty) begin
      cp_accum  = '0;
      cont_left = '0;
      skip_rest = 1'b0;
      put_char(CH_QUOTE, 1'b0);
      put_char(CH_QUOTE, 1'b1);
    end else begin
      if (first) begin
        cp_accum  = '0;
        cont_left = '0;
        skip_rest = 1'b0;
        put_char(CH_QUOTE, 1'b0);
      end
      if (skip_rest) begin
        if (last) begin
          skip_rest = 1'b0;
        end
      end else begin
        take_byte(b, last);
      end
    end
    if (item_chars.size() > 0) begin
      item_chars[item_chars.size() - 1].run_last = 1'b1;
    end
    for (k = 0; k < item_chars.size(); k++) begin
      expected_chars.insert(expected_chars.size(), item_chars[k]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chars.delete();
      cp_accum       = '0;
      cont_left      = '0;
      skip_rest      = 1'b0;
      errs           = 0;
      checked        = 0;
      mismatch_count <= 0;
      chars_pending  <= 0;
      chars_checked  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_escape(in_data_byte, in_first_of_string, in_last_of_string,
                       in_empty_string);
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_chars.size() == 0) begin
          $error("out_char 8'h%02h arrived with no character expected", out_char);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected 8'h%02h, actual 8'h%02h", want.ch, out_char);
            errs++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %b, actual %b", want.run_last, out_run_last);
            errs++;
          end
          if (out_closes_string !== want.closes) begin
            $error("out_closes_string: expected %b, actual %b", want.closes,
                   out_closes_string);
            errs++;
          end
        end
      end
      mismatch_count <= errs;
      chars_pending  <= expected_chars.size();
      chars_checked  <= checked;
    end
  end

endmodule

// ----- verif/json_string_utf8_escaper_tb.sv -----
// Top of the escaper testbench: clock, reset, request stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module json_string_utf8_escaper_tb;
  import jsue_pkg::*;
  import json_escape_tb_pkg::*;

  // Roughly how many input requests the run offers in total.
  localparam int ITEM_TARGET  = 450;
  // The receiver's long hold-off: when it starts after reset, and how long.
  localparam int HOLD_START   = 400;
  localparam int HOLD_LEN     = 250;
  // Quiet cycles after the last expected character, to catch strays.
  localparam int DRAIN_CYCLES = 40;
  // Hard stop; far beyond the slowest legal run of this stimulus.
  localparam int TIMEOUT_NS   = 2400000;

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_valid           = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte       = 8'h00;
  logic       in_first_of_string = 1'b0;
  logic       in_last_of_string  = 1'b0;
  logic       in_empty_string    = 1'b0;
  logic       out_valid;
  logic       out_ready          = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_closes_string;

  int mismatch_count;
  int chars_pending;
  int chars_checked;

  // Stimulus bookkeeping.
  int items_sent     = 0;
  int directed_items = 0;
  int burst_left     = 0;

  // Bytes of the string that the sender is about to offer.
  logic [7:0] text_bytes[$];

  // Receiver state, owned by the receiver process alone.
  int rx_cycle  = 0;
  int hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  json_string_utf8_escaper u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_of_string(in_first_of_string),
    .in_last_of_string (in_last_of_string),
    .in_empty_string   (in_empty_string),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_closes_string (out_closes_string)
  );

  json_escape_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_of_string(in_first_of_string),
    .in_last_of_string (in_last_of_string),
    .in_empty_string   (in_empty_string),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_run_last      (out_run_last),
    .out_closes_string (out_closes_string),
    .mismatch_count    (mismatch_count),
    .chars_pending     (chars_pending),
    .chars_checked     (chars_checked)
  );

  // Offer one request and hold it until the block takes it. The sender works
  // in bursts: when a burst runs out, valid drops for a short random gap and a
  // new burst length is drawn. About one burst in four is long, which gives
  // stretches where requests follow each other back to back.
  task automatic offer_request(input logic [7:0] b, input logic first,
                               input logic last, input logic empty);
    int gap;
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_first_of_string <= first;
    in_last_of_string  <= last;
    in_empty_string    <= empty;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send text_bytes as one string. The first byte carries the opening flag
  // unless with_first is clear, which models bytes arriving outside a string.
  // restart_at puts an extra opening flag on that byte, so a new string cuts
  // into the old one, possibly in the middle of a multi-byte sequence.
  task automatic send_text(input bit with_first, input bit with_last,
                           input int restart_at);
    int i;
    for (i = 0; i < text_bytes.size(); i++) begin
      offer_request(text_bytes[i], (i == 0 && with_first) || i == restart_at,
                    with_last && i == text_bytes.size() - 1, 1'b0);
    end
  endtask

  // Fill text_bytes with a string that is mostly valid UTF-8: plain ASCII,
  // characters that need an escape, two- and three-byte sequences, and now
  // and then an arbitrary byte that usually breaks the string.
  task automatic build_random_text();
    int n;
    int kind;
    text_bytes.delete();
    n = $urandom_range(1, 10);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(32, 126)));
      end else if (kind < 62) begin
        case ($urandom_range(0, 6))
          0:       text_bytes.insert(text_bytes.size(), CH_QUOTE);
          1:       text_bytes.insert(text_bytes.size(), CH_BSLASH);
          2:       text_bytes.insert(text_bytes.size(), BYTE_LF);
          3:       text_bytes.insert(text_bytes.size(), BYTE_TAB);
          4:       text_bytes.insert(text_bytes.size(), BYTE_BS);
          5:       text_bytes.insert(text_bytes.size(), BYTE_FF);
          default: text_bytes.insert(text_bytes.size(), BYTE_CR);
        endcase
      end else if (kind < 77) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'hC0, 8'hDF)));
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 92) begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'hE0, 8'hEF)));
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // The receiver. After reset it cycles through four stall patterns of its
  // own: always ready, mostly ready, ready one cycle in three, and mostly
  // stalled. Once, at a fixed cycle count, it holds off for a long stretch
  // so that the block's command queue fills and in_ready drops while the
  // sender keeps a request waiting.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle == HOLD_START) begin
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 96) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) < 7);
          2:       out_ready <= (rx_cycle % 3 == 0);
          default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int mode;
    int restart;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty-string request with junk in the ignored fields
    // gives just the two quotes.
    offer_request(8'hFF, 1'b1, 1'b1, 1'b1);

    // Lowest printable byte, the two characters that take a backslash, and
    // the highest byte that is still passed through as it is.
    text_bytes = '{8'h20, CH_QUOTE, CH_BSLASH, 8'h7F};
    send_text(1'b1, 1'b1, -1);

    // Newline and tab are escaped; backspace, form feed and carriage return
    // vanish, the last one while also closing the string.
    text_bytes = '{BYTE_LF, BYTE_TAB, BYTE_BS, BYTE_FF, BYTE_CR};
    send_text(1'b1, 1'b1, -1);

    // A two-byte and a three-byte sequence, decoded to lowercase hex.
    text_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC};
    send_text(1'b1, 1'b1, -1);

    // A four-byte lead fails at once; its continuation bytes are dropped and
    // the closing flag on the last of them only ends the dropping.
    text_bytes = '{8'hF0, 8'h90, 8'h80};
    send_text(1'b1, 1'b1, -1);

    // A lone continuation byte fails; the top byte value is then dropped.
    text_bytes = '{8'h80, 8'hFF};
    send_text(1'b1, 1'b1, -1);

    // A lead whose continuation never comes: the plain byte fails it and the
    // string keeps dropping bytes until the next opening flag.
    offer_request(8'hC3, 1'b1, 1'b0, 1'b0);
    offer_request(8'h41, 1'b0, 1'b0, 1'b0);

    // That opening flag starts a three-byte sequence, and another opening
    // flag cuts it off without any mark.
    offer_request(8'hE2, 1'b1, 1'b0, 1'b0);
    offer_request(8'h41, 1'b1, 1'b1, 1'b0);

    // A sequence cut off by the end of the string, then a lead that is
    // itself the last byte.
    text_bytes = '{8'hE2, 8'h82};
    send_text(1'b1, 1'b1, -1);
    offer_request(8'hC3, 1'b1, 1'b1, 1'b0);

    // Bytes after the string has closed, with no opening flag: no opening
    // quote; the plain byte passes and the null byte fails and closes the string.
    text_bytes = '{8'h42, 8'h00};
    send_text(1'b0, 1'b1, -1);
    directed_items = items_sent;

    // Random part. Most requests are whole strings with random content; the
    // rest are empty-string markers with junk fields, strings missing their
    // opening or closing flag, strings cut short, and strings cut into by a
    // new opening flag.
    while (items_sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
        offer_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1);
      end else begin
        build_random_text();
        if (mode == 1 && text_bytes.size() > 1) begin
          text_bytes.delete(text_bytes.size() - 1);
        end
        restart = (mode == 2) ? $urandom_range(0, text_bytes.size() - 1) : -1;
        send_text(mode != 3, mode != 4, restart);
      end
    end
    in_valid <= 1'b0;

    // The checker's pending count is registered and lags the queue, so step the
    // clock before looking at it; then let any stray character show up.
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input requests (%0d directed) and %0d output characters.",
             items_sent, directed_items, chars_checked);
    $display("The receiver once held off for %0d cycles with requests still offered.",
             HOLD_LEN);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- json_string_utf8_escaper.f -----
sv/jsue_pkg.sv
sv/jsue_front.sv
sv/jsue_cmdq.sv
sv/jsue_back.sv
sv/json_string_utf8_escaper.sv
verif/json_escape_tb_pkg.sv
verif/json_escape_checker.sv
verif/json_string_utf8_escaper_tb.sv
